@@ hw/rtl/pps_rs_pkg.sv @@
// Package for the PPS re-arm supervisor: field widths, register indexes,
// reset values and pulse-width conversion constants. No dependencies.
package pps_rs_pkg;

  localparam int unsigned TickW   = 32;
  localparam int unsigned SecW    = 32;
  localparam int unsigned NsW     = 30;
  localparam int unsigned OffW    = 8;
  localparam int unsigned WHighW  = 6;
  localparam int unsigned WLowW   = 8;
  localparam int unsigned WCountW = WHighW + WLowW;
  localparam int unsigned UnitW   = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;
  // guard length in ms: count (at most 2^14 - 1) plus one
  localparam int unsigned GlenW   = WCountW + 1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSecondOffset = 3'd0,
    CfgRearmTimeout = 3'd1,
    CfgRestartGuard = 3'd2,
    CfgWidthHigh    = 3'd3,
    CfgWidthLow     = 3'd4,
    CfgWidthUnit    = 3'd5
  } cfg_idx_e;

  typedef enum logic [UnitW-1:0] {
    Unit120ns = 2'd0,
    Unit1us   = 2'd1,
    Unit1ms   = 2'd2,
    Unit1usB  = 2'd3
  } width_unit_e;

  localparam logic [OffW-1:0]    SecondOffsetRst = 8'd1;
  localparam logic [TickW-1:0]   RearmTimeoutRst = 32'd2000;
  localparam logic [TickW-1:0]   RestartGuardRst = 32'd3000;
  localparam logic [WHighW-1:0]  WidthHighRst    = 6'd0;
  localparam logic [WLowW-1:0]   WidthLowRst     = 8'd100;
  localparam logic [UnitW-1:0]   WidthUnitRst    = Unit1ms;

  localparam logic [NsW-1:0] HalfSecondNs = 30'd500000000;

  // ceil(count / 1000) via reciprocal multiply, exact for 15-bit dividends
  localparam int unsigned UsPerMs     = 1000;
  localparam int unsigned RecipShift  = 26;
  localparam int unsigned RecipW      = 17;
  localparam logic [RecipW-1:0] RecipMs = RecipW'((2**RecipShift + UsPerMs - 1) / UsPerMs);
  localparam logic [GlenW-1:0]  UsRound = GlenW'(UsPerMs - 1);

  // 120 ns units: count * 120 fits in 21 bits, ceil to ms is 1 or 2
  localparam int unsigned NsUnitW  = 21;
  localparam logic [NsUnitW-1:0] NsPerUnit = NsUnitW'(120);
  localparam logic [NsUnitW-1:0] NsPerMs   = NsUnitW'(1000000);

endpackage

@@ hw/rtl/pps_rearm_supervisor_core.sv @@
// PPS re-arm supervisor: input register, single-pass decision logic, result register.
// An input transaction is captured in the input register and then moves into the result
// register. Throughput: one poll per cycle unless out_ready_i stalls the result; an input
// transaction is taken whenever the input register is empty or moving into the result
// register. Guard length is re-derived from configuration into a register every cycle.
// Reset (rst_ni low, async) clears the window state, valid flags and loads configuration
// register reset values.
module pps_rearm_supervisor_core
  import pps_rs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [TickW-1:0]    tick_ms_i,
  input  logic                restart_notice_i,
  input  logic                done_flag_i,
  input  logic [NsW-1:0]      clock_nanoseconds_i,
  input  logic [SecW-1:0]     clock_seconds_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                clear_done_o,
  output logic                arm_now_o,
  output logic [SecW-1:0]     target_second_o,
  output logic                guard_open_o
);

  // configuration
  logic [OffW-1:0]   second_offset_q;
  logic [TickW-1:0]  rearm_timeout_q;
  logic [TickW-1:0]  restart_guard_q;
  logic [WHighW-1:0] width_high_q;
  logic [WLowW-1:0]  width_low_q;
  logic [UnitW-1:0]  width_unit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      second_offset_q <= SecondOffsetRst;
      rearm_timeout_q <= RearmTimeoutRst;
      restart_guard_q <= RestartGuardRst;
      width_high_q    <= WidthHighRst;
      width_low_q     <= WidthLowRst;
      width_unit_q    <= WidthUnitRst;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgSecondOffset: second_offset_q <= cfg_data_i[OffW-1:0];
        CfgRearmTimeout: rearm_timeout_q <= cfg_data_i[TickW-1:0];
        CfgRestartGuard: restart_guard_q <= cfg_data_i[TickW-1:0];
        CfgWidthHigh:    width_high_q    <= cfg_data_i[WHighW-1:0];
        CfgWidthLow:     width_low_q     <= cfg_data_i[WLowW-1:0];
        CfgWidthUnit:    width_unit_q    <= cfg_data_i[UnitW-1:0];
        default: ;
      endcase
    end
  end

  // guard length in ms
  logic [WCountW-1:0]          wcount;
  logic [GlenW-1:0]            us_sum;
  logic [GlenW+RecipW-1:0]     us_prod;
  logic [NsUnitW-1:0]          ns_total;
  logic [GlenW-1:0]            glen_base;
  logic [GlenW-1:0]            glen_d, glen_q;

  always_comb begin
    wcount = {width_high_q, width_low_q};
    if (wcount == '0) begin
      wcount = WCountW'(1);
    end
    us_sum   = {1'b0, wcount} + UsRound;
    us_prod  = GlenW'(us_sum) * RecipMs;
    ns_total = NsUnitW'(wcount) * NsPerUnit;
    case (width_unit_e'(width_unit_q))
      Unit1ms:           glen_base = {1'b0, wcount};
      Unit1us, Unit1usB: glen_base = GlenW'(us_prod >> RecipShift);
      default:           glen_base = (ns_total > NsPerMs) ? GlenW'(2) : GlenW'(1);
    endcase
    glen_d = glen_base + GlenW'(1);
  end

  always_ff @(posedge clk_i) begin
    glen_q <= glen_d;
  end

  // input register
  logic             in_valid_q;
  logic [TickW-1:0] tick_q;
  logic             restart_q, done_q;
  logic [NsW-1:0]   ns_q;
  logic [SecW-1:0]  sec_q;
  logic             advance;

  assign advance    = in_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      tick_q    <= tick_ms_i;
      restart_q <= restart_notice_i;
      done_q    <= done_flag_i;
      ns_q      <= clock_nanoseconds_i;
      sec_q     <= clock_seconds_i;
    end
  end

  // supervisor state
  logic             guard_pending_q, guard_pending_d;
  logic [TickW-1:0] done_seen_q, done_seen_d;
  logic [TickW-1:0] last_arm_q, last_arm_d;
  logic [TickW-1:0] last_restart_q, last_restart_d;

  logic             gp_open, expire, force_arm, rearm;
  logic [TickW-1:0] done_elapsed;
  logic             clear_d, arm_d, gopen_d;
  logic [SecW-1:0]  target_d;

  always_comb begin
    guard_pending_d = guard_pending_q;
    done_seen_d     = done_seen_q;
    last_arm_d      = last_arm_q;
    last_restart_d  = last_restart_q;
    gp_open         = guard_pending_q;
    done_elapsed    = '0;
    expire          = 1'b0;
    force_arm       = 1'b0;
    rearm           = 1'b0;
    target_d        = '0;
    if (restart_q) begin
      last_restart_d  = tick_q;
      last_arm_d      = tick_q;
      guard_pending_d = 1'b0;
    end else begin
      if (!guard_pending_q && done_q) begin
        gp_open     = 1'b1;
        done_seen_d = tick_q;
      end
      done_elapsed = tick_q - done_seen_d;
      expire       = gp_open && (done_elapsed >= TickW'(glen_q));
      force_arm    = !gp_open && ((tick_q - last_arm_q) >= rearm_timeout_q)
                     && ((tick_q - last_restart_q) >= restart_guard_q);
      rearm        = expire || force_arm;
      guard_pending_d = gp_open && !expire;
      if (rearm) begin
        target_d   = sec_q + SecW'(second_offset_q) + SecW'(ns_q >= HalfSecondNs);
        last_arm_d = tick_q;
      end
    end
    clear_d = expire;
    arm_d   = rearm;
    gopen_d = guard_pending_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      guard_pending_q <= 1'b0;
      done_seen_q     <= '0;
      last_arm_q      <= '0;
      last_restart_q  <= '0;
      out_valid_o     <= 1'b0;
    end else begin
      if (advance) begin
        guard_pending_q <= guard_pending_d;
        done_seen_q     <= done_seen_d;
        last_arm_q      <= last_arm_d;
        last_restart_q  <= last_restart_d;
        out_valid_o     <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      clear_done_o    <= clear_d;
      arm_now_o       <= arm_d;
      target_second_o <= target_d;
      guard_open_o    <= gopen_d;
    end
  end

endmodule

@@ hw/rtl/pps_rs_checker.sv @@
// Port-level checks for the PPS re-arm supervisor, bound to the core.
// Depends on pps_rs_pkg and pps_rearm_supervisor_core.
module pps_rs_checker
  import pps_rs_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input logic            clear_done_o,
  input logic            arm_now_o,
  input logic [SecW-1:0] target_second_o,
  input logic            guard_open_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(target_second_o)
      && $stable(arm_now_o) && $stable(clear_done_o) && $stable(guard_open_o))
    else $error("result changed while stalled");

  a_target_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !arm_now_o |-> target_second_o == '0)
    else $error("target second set without arm");

  a_clear_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clear_done_o |-> arm_now_o)
    else $error("done cleared without re-arm");

  a_arm_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && arm_now_o |-> !guard_open_o)
    else $error("guard left open on re-arm");

endmodule

bind pps_rearm_supervisor_core pps_rs_checker u_pps_rs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .clear_done_o    (clear_done_o),
  .arm_now_o       (arm_now_o),
  .target_second_o (target_second_o),
  .guard_open_o    (guard_open_o)
);
